// ===== sv/utf8_to_utf16_transcoder_assert.svh =====
// Assertion macros for the UTF-8 to UTF-16 transcoder checker.
// Depends on nothing; included by the checker file.
`ifndef UTF8_TO_UTF16_TRANSCODER_ASSERT_SVH
`define UTF8_TO_UTF16_TRANSCODER_ASSERT_SVH

// Check cons in the same cycle as ante.
`define U8_ASSERT_NOW(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante.
`define U8_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/u8to16_pkg.sv =====
// Types and constants for the UTF-8 to UTF-16 transcoder.
// Depends on nothing; imported by every module of the block.
package u8to16_pkg;

	localparam logic [2:0] ST_UNIT     = 3'd0;
	localparam logic [2:0] ST_END      = 3'd1;
	localparam logic [2:0] ST_BAD_LEAD = 3'd2;
	localparam logic [2:0] ST_TRUNC    = 3'd3;
	localparam logic [2:0] ST_INCOMP   = 3'd4;
	localparam logic [2:0] ST_INVALID  = 3'd5;
	localparam logic [2:0] ST_OVERLONG = 3'd6;

	localparam logic [20:0] POINT_MAX = 21'h10ffff;
	localparam logic [20:0] SURR_LO   = 21'h00d800;
	localparam logic [20:0] SURR_HI   = 21'h00dfff;
	localparam logic [20:0] LIM_ONE   = 21'h000080;
	localparam logic [20:0] LIM_TWO   = 21'h000800;
	localparam logic [20:0] LIM_THREE = 21'h010000;
	localparam logic [15:0] HIGH_BASE = 16'hd7c0;
	localparam logic [15:0] LOW_BASE  = 16'hdc00;

	typedef struct packed {
		logic [15:0] unit_value;
		logic [2:0]  status;
		logic        string_end;
		logic        last_of_run;
	} res_t;

	typedef struct packed {
		logic [1:0] count;
		res_t       r0;
		res_t       r1;
	} dec_t;

endpackage

// ===== sv/u8to16_decode.sv =====
// Decode state and result logic for one UTF-8 byte.
// Depends on u8to16_pkg; instantiated by utf8_to_utf16_transcoder.
module u8to16_decode import u8to16_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  logic [7:0] byte_s1,
	output dec_t       dec
);

	logic [1:0]  rem_q, rem_n;
	logic [2:0]  seq_q, seq_n;
	logic [20:0] pp_q, pp_n;
	logic        failed_q, failed_n;

	logic [20:0] pp_cat;
	logic [20:0] cp_sel;
	logic [2:0]  len_sel;
	logic        is_invalid;
	logic        is_overlong;
	logic [15:0] hi_unit;
	logic [15:0] lo_unit;
	logic        emit_en;

	assign pp_cat  = {pp_q[14:0], byte_s1[5:0]};
	assign cp_sel  = (rem_q != 2'd0) ? pp_cat : {13'd0, byte_s1};
	assign len_sel = (rem_q != 2'd0) ? seq_q : 3'd1;

	assign is_invalid = (cp_sel > POINT_MAX) || ((cp_sel >= SURR_LO) && (cp_sel <= SURR_HI));

	always_comb begin
		priority if (cp_sel < LIM_ONE) begin
			is_overlong = (len_sel != 3'd1);
		end else if (cp_sel < LIM_TWO) begin
			is_overlong = (len_sel != 3'd2);
		end else if (cp_sel < LIM_THREE) begin
			is_overlong = (len_sel != 3'd3);
		end else begin
			is_overlong = 1'b0;
		end
	end

	assign hi_unit = {5'd0, cp_sel[20:10]} + HIGH_BASE;
	assign lo_unit = {6'd0, cp_sel[9:0]} + LOW_BASE;

	always_comb begin
		rem_n     = rem_q;
		seq_n     = seq_q;
		pp_n      = pp_q;
		failed_n  = failed_q;
		emit_en   = 1'b0;
		dec.count = 2'd0;
		dec.r0    = '{unit_value: 16'd0, status: ST_UNIT, string_end: 1'b1, last_of_run: 1'b1};
		dec.r1    = '{unit_value: 16'd0, status: ST_UNIT, string_end: 1'b0, last_of_run: 1'b1};

		if (failed_q) begin
			// drop bytes until the terminating zero
			if (byte_s1 == 8'd0) begin
				failed_n = 1'b0;
			end
		end else if (rem_q != 2'd0) begin
			if (byte_s1 == 8'd0) begin
				rem_n = 2'd0;
				seq_n = 3'd0;
				pp_n = 21'd0;
				dec.count = 2'd1;
				dec.r0.status = ST_TRUNC;
			end else if (byte_s1[7:6] != 2'b10) begin
				rem_n = 2'd0;
				seq_n = 3'd0;
				pp_n = 21'd0;
				failed_n = 1'b1;
				dec.count = 2'd1;
				dec.r0.status = ST_INCOMP;
			end else begin
				pp_n = pp_cat;
				rem_n = rem_q - 2'd1;
				emit_en = (rem_q == 2'd1);
			end
		end else if (byte_s1 == 8'd0) begin
			rem_n = 2'd0;
			seq_n = 3'd0;
			pp_n = 21'd0;
			dec.count = 2'd1;
			dec.r0.status = ST_END;
		end else if (!byte_s1[7]) begin
			emit_en = 1'b1;
		end else if (byte_s1[7:5] == 3'b110) begin
			seq_n = 3'd2;
			rem_n = 2'd1;
			pp_n = {16'd0, byte_s1[4:0]};
		end else if (byte_s1[7:4] == 4'b1110) begin
			seq_n = 3'd3;
			rem_n = 2'd2;
			pp_n = {17'd0, byte_s1[3:0]};
		end else if (byte_s1[7:3] == 5'b11110) begin
			seq_n = 3'd4;
			rem_n = 2'd3;
			pp_n = {18'd0, byte_s1[2:0]};
		end else begin
			failed_n = 1'b1;
			dec.count = 2'd1;
			dec.r0.status = ST_BAD_LEAD;
		end

		if (emit_en) begin
			rem_n = 2'd0;
			seq_n = 3'd0;
			pp_n = 21'd0;
			dec.count = 2'd1;
			if (is_invalid) begin
				failed_n = 1'b1;
				dec.r0.status = ST_INVALID;
			end else if (is_overlong) begin
				failed_n = 1'b1;
				dec.r0.status = ST_OVERLONG;
			end else if (cp_sel >= LIM_THREE) begin
				dec.count = 2'd2;
				dec.r0 = '{unit_value: hi_unit, status: ST_UNIT, string_end: 1'b0,
					last_of_run: 1'b0};
				dec.r1 = '{unit_value: lo_unit, status: ST_UNIT, string_end: 1'b0,
					last_of_run: 1'b1};
			end else begin
				dec.r0 = '{unit_value: cp_sel[15:0], status: ST_UNIT, string_end: 1'b0,
					last_of_run: 1'b1};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q    <= 2'd0;
			seq_q    <= 3'd0;
			pp_q     <= 21'd0;
			failed_q <= 1'b0;
		end else if (advance) begin
			rem_q    <= rem_n;
			seq_q    <= seq_n;
			pp_q     <= pp_n;
			failed_q <= failed_n;
		end
	end

endmodule

// ===== sv/u8to16_outq.sv =====
// Four-entry result queue: takes up to two results a cycle, gives one.
// Depends on u8to16_pkg; instantiated by utf8_to_utf16_transcoder.
module u8to16_outq import u8to16_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  dec_t dec,
	input  logic pop,
	output logic has_room,
	output logic not_empty,
	output res_t head
);

	localparam int Depth = 4;
	localparam int PtrW  = $clog2(Depth);

	res_t            res_q [Depth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [PtrW:0]   count_q;
	logic [PtrW-1:0] wr_ptr_b;
	logic [PtrW:0]   push_n;

	assign wr_ptr_b  = wr_ptr_q + PtrW'(1);
	assign push_n    = push ? {{(PtrW-1){1'b0}}, dec.count} : '0;
	assign has_room  = (count_q <= (PtrW+1)'(Depth - 2));
	assign not_empty = (count_q != '0);
	assign head      = res_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		for (int i = 0; i < Depth; i++) begin
			if (push && (dec.count != 2'd0) && (wr_ptr_q == PtrW'(i))) begin
				res_q[i] <= dec.r0;
			end
			if (push && (dec.count == 2'd2) && (wr_ptr_b == PtrW'(i))) begin
				res_q[i] <= dec.r1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_n[PtrW-1:0];
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PtrW'(1);
			end
			count_q <= count_q + push_n - ((PtrW+1)'(pop));
		end
	end

endmodule

// ===== sv/utf8_to_utf16_transcoder.sv =====
// Top level of the UTF-8 to UTF-16 transcoder.
// Depends on u8to16_pkg, u8to16_decode and u8to16_outq.
//
// Accepts one UTF-8 byte per cycle while the queue has room and gives one
// result per cycle while out_stall is low: a byte is registered, decoded and
// written to a four-entry result queue, which holds its results until read.
// A byte that completes a code point above 0xFFFF gives a surrogate pair,
// which leaves one unit at a time; the queue's single read port sets the
// output rate, and input is held while fewer than two queue entries are free.
// A byte that only advances a sequence, or any byte after an error up to the
// terminating zero, gives no result.
module utf8_to_utf16_transcoder import u8to16_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] unit_value,
	output logic [2:0]  status,
	output logic        string_end,
	output logic        last_of_run
);

	logic [7:0] byte_s1;
	logic       valid_s1;
	logic       advance;
	logic       has_room;
	logic       pop;
	dec_t       dec;
	res_t       head;

	assign advance  = valid_s1 && has_room;
	assign in_stall = valid_s1 && !has_room;
	assign pop      = out_valid && !out_stall;

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	u8to16_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.byte_s1 (byte_s1),
		.dec     (dec)
	);

	u8to16_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance),
		.dec       (dec),
		.pop       (pop),
		.has_room  (has_room),
		.not_empty (out_valid),
		.head      (head)
	);

	assign unit_value  = head.unit_value;
	assign status      = head.status;
	assign string_end  = head.string_end;
	assign last_of_run = head.last_of_run;

endmodule

// ===== sv/u8to16_checker.sv =====
// Port-level checks for the UTF-8 to UTF-16 transcoder, bound to the top.
// Depends on u8to16_pkg and utf8_to_utf16_transcoder_assert.svh.
`include "utf8_to_utf16_transcoder_assert.svh"

module u8to16_checker import u8to16_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [15:0] unit_value,
	input logic [2:0]  status,
	input logic        string_end,
	input logic        last_of_run
);

	logic [20:0] res_bits;
	logic        stalled;
	logic        is_unit;
	logic        closes;
	logic        hi_surr;

	assign res_bits = {unit_value, status, string_end, last_of_run};
	assign stalled  = out_valid && out_stall;
	assign is_unit  = (status == ST_UNIT);
	assign closes   = string_end && last_of_run && (unit_value == 16'd0);
	assign hi_surr  = is_unit && (unit_value[15:10] == 6'b110110);

	`U8_ASSERT_NEXT(a_out_hold, clk, arst_n, stalled, out_valid && $stable(res_bits), "stall not held")
	`U8_ASSERT_NOW(a_err_closes, clk, arst_n, out_valid && !is_unit, closes, "string not closed")
	`U8_ASSERT_NOW(a_unit_open, clk, arst_n, out_valid && is_unit, !string_end, "unit closes string")
	`U8_ASSERT_NOW(a_high_surr, clk, arst_n, out_valid && hi_surr, !last_of_run, "lead surrogate last")
	`U8_ASSERT_NOW(a_status_rng, clk, arst_n, out_valid, status <= ST_OVERLONG, "status out of range")

endmodule

bind utf8_to_utf16_transcoder u8to16_checker u_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Testbench for utf8_to_utf16_transcoder: directed and random zero-terminated strings,
// each result checked against a decoder kept in a small scoreboard class.
// Depends on u8to16_pkg and the transcoder RTL.

import u8to16_pkg::*;

class unit_tracker;
	res_t        units_due[$];
	logic [1:0]  cont_left;
	logic [2:0]  seq_bytes;
	logic [20:0] point_acc;
	bit          dropping;
	int          n_bytes;
	int          n_live;
	int          n_results;
	int          n_pairs;
	int          n_rejects;
	int          mismatches;

	function new();
		cont_left  = '0;
		seq_bytes  = '0;
		point_acc  = '0;
		dropping   = 1'b0;
		n_bytes    = 0;
		n_live     = 0;
		n_results  = 0;
		n_pairs    = 0;
		n_rejects  = 0;
		mismatches = 0;
	endfunction

	function void due(logic [15:0] unit, logic [2:0] st, logic fin, logic last);
		res_t r;
		r.unit_value  = unit;
		r.status      = st;
		r.string_end  = fin;
		r.last_of_run = last;
		units_due.push_back(r);
	endfunction

	function void clear_seq();
		cont_left = '0;
		seq_bytes = '0;
		point_acc = '0;
	endfunction

	function void reject(logic [2:0] st, bit ends_here);
		clear_seq();
		dropping = !ends_here;
		n_rejects++;
		due(16'h0000, st, 1'b1, 1'b1);
	endfunction

	function void finish_point(logic [20:0] cp, logic [2:0] len);
		logic [2:0] fit;
		fit = (cp < LIM_ONE) ? 3'd1 : (cp < LIM_TWO) ? 3'd2 : (cp < LIM_THREE) ? 3'd3 : 3'd4;
		if (cp > POINT_MAX || (cp >= SURR_LO && cp <= SURR_HI)) begin
			reject(ST_INVALID, 1'b0);
		end else if (fit != len) begin
			reject(ST_OVERLONG, 1'b0);
		end else begin
			clear_seq();
			if (cp >= LIM_THREE) begin
				n_pairs++;
				due({5'd0, cp[20:10]} + HIGH_BASE, ST_UNIT, 1'b0, 1'b0);
				due({6'd0, cp[9:0]} + LOW_BASE, ST_UNIT, 1'b0, 1'b1);
			end else begin
				due(cp[15:0], ST_UNIT, 1'b0, 1'b1);
			end
		end
	endfunction

	// Note an accepted byte and queue the results it causes.
	function void note_byte(logic [7:0] b);
		n_bytes++;
		if (dropping) begin
			if (b == 8'h00)
				dropping = 1'b0;
			return;
		end
		n_live++;
		if (cont_left != 2'd0) begin
			if (b == 8'h00) begin
				reject(ST_TRUNC, 1'b1);
			end else if (b[7:6] != 2'b10) begin
				reject(ST_INCOMP, 1'b0);
			end else begin
				point_acc = {point_acc[14:0], b[5:0]};
				cont_left = cont_left - 2'd1;
				if (cont_left == 2'd0)
					finish_point(point_acc, seq_bytes);
			end
			return;
		end
		if (b == 8'h00) begin
			clear_seq();
			due(16'h0000, ST_END, 1'b1, 1'b1);
		end else if (!b[7]) begin
			finish_point({13'd0, b}, 3'd1);
		end else if (b[7:5] == 3'b110) begin
			seq_bytes = 3'd2;
			point_acc = {16'd0, b[4:0]};
			cont_left = 2'd1;
		end else if (b[7:4] == 4'b1110) begin
			seq_bytes = 3'd3;
			point_acc = {17'd0, b[3:0]};
			cont_left = 2'd2;
		end else if (b[7:3] == 5'b11110) begin
			seq_bytes = 3'd4;
			point_acc = {18'd0, b[2:0]};
			cont_left = 2'd3;
		end else begin
			reject(ST_BAD_LEAD, 1'b0);
		end
	endfunction

	function void compare(string field, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
			mismatches++;
		end
	endfunction

	function void check_result(res_t got);
		res_t want;
		if (units_due.size() == 0) begin
			$display("%0t: unexpected result, expected none, actual unit 0x%0h status %0d",
				$time, got.unit_value, got.status);
			mismatches++;
			return;
		end
		want = units_due.pop_front();
		n_results++;
		compare("unit_value", want.unit_value, got.unit_value);
		compare("status", {13'd0, want.status}, {13'd0, got.status});
		compare("string_end", {15'd0, want.string_end}, {15'd0, got.string_end});
		compare("last_of_run", {15'd0, want.last_of_run}, {15'd0, got.last_of_run});
	endfunction
endclass

module tb;

	localparam int CYCLE_LIMIT = 200000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] unit_value;
	logic [2:0]  status;
	logic        string_end;
	logic        last_of_run;

	unit_tracker sb;
	logic [7:0]  line_q[$];
	int          send_idle;
	int          recv_idle;
	int          hold_left;
	int          cycle_count;

	utf8_to_utf16_transcoder u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.unit_value  (unit_value),
		.status      (status),
		.string_end  (string_end),
		.last_of_run (last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	function automatic int nat_len(logic [20:0] cp);
		return (cp < LIM_ONE) ? 1 : (cp < LIM_TWO) ? 2 : (cp < LIM_THREE) ? 3 : 4;
	endfunction

	// Encode cp in exactly len bytes, overlong or out of range as given.
	function automatic void put_point(logic [20:0] cp, int len);
		case (len)
			1: line_q.push_back({1'b0, cp[6:0]});
			2: begin
				line_q.push_back({3'b110, cp[10:6]});
				line_q.push_back({2'b10, cp[5:0]});
			end
			3: begin
				line_q.push_back({4'b1110, cp[15:12]});
				line_q.push_back({2'b10, cp[11:6]});
				line_q.push_back({2'b10, cp[5:0]});
			end
			default: begin
				line_q.push_back({5'b11110, cp[20:18]});
				line_q.push_back({2'b10, cp[17:12]});
				line_q.push_back({2'b10, cp[11:6]});
				line_q.push_back({2'b10, cp[5:0]});
			end
		endcase
	endfunction

	function automatic void add_random_string();
		int          nchar;
		int          pick;
		int          len;
		int          mark;
		logic [20:0] cp;
		nchar = $urandom_range(0, 8);
		for (int i = 0; i < nchar; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 25) begin
				put_point(21'($urandom_range(1, 'h7f)), 1);
			end else if (pick < 37) begin
				put_point(21'($urandom_range('h80, 'h7ff)), 2);
			end else if (pick < 49) begin
				cp = 21'($urandom_range('h800, 'hffff));
				if (cp >= SURR_LO && cp <= SURR_HI)
					cp = cp ^ 21'h002000;
				put_point(cp, 3);
			end else if (pick < 61) begin
				put_point(21'($urandom_range('h10000, 'h10ffff)), 4);
			end else if (pick < 67) begin
				case ($urandom_range(0, 9))
					0: cp = 21'h000001;
					1: cp = 21'h00007f;
					2: cp = 21'h000080;
					3: cp = 21'h0007ff;
					4: cp = 21'h000800;
					5: cp = 21'h00d7ff;
					6: cp = 21'h00e000;
					7: cp = 21'h00ffff;
					8: cp = 21'h010000;
					default: cp = 21'h10ffff;
				endcase
				put_point(cp, nat_len(cp));
			end else if (pick < 71) begin
				len = $urandom_range(2, 4);
				cp = 21'($urandom_range(0, (len == 2) ? 'h7f : (len == 3) ? 'h7ff : 'hffff));
				put_point(cp, len);
			end else if (pick < 74) begin
				put_point(21'($urandom_range(SURR_LO, SURR_HI)), 3);
			end else if (pick < 77) begin
				put_point(21'($urandom_range('h110000, 'h1fffff)), 4);
			end else if (pick < 80) begin
				line_q.push_back($urandom_range(0, 1) ? 8'($urandom_range('h80, 'hbf))
					: 8'($urandom_range('hf8, 'hff)));
			end else if (pick < 84) begin
				len = $urandom_range(2, 4);
				mark = line_q.size();
				put_point(21'($urandom), len);
				line_q[mark + $urandom_range(1, len - 1)] = $urandom_range(0, 1)
					? 8'($urandom_range(1, 'h7f)) : 8'($urandom_range('hc0, 'hff));
			end else if (pick < 88) begin
				// cut the sequence short; the terminator follows
				len = $urandom_range(2, 4);
				put_point(21'($urandom), len);
				repeat ($urandom_range(1, len - 1))
					void'(line_q.pop_back());
				break;
			end else begin
				line_q.push_back(8'($urandom_range(1, 255)));
			end
		end
		line_q.push_back(8'h00);
	endfunction

	task automatic send_byte(logic [7:0] b);
		in_valid  <= 1'b1;
		data_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_byte(b);
		if ($urandom_range(0, 99) < send_idle) begin
			in_valid  <= 1'b0;
			data_byte <= 8'($urandom);
			@(posedge clk);
			while ($urandom_range(0, 99) < send_idle)
				@(posedge clk);
		end
	endtask

	task automatic send_line();
		while (line_q.size() != 0)
			send_byte(line_q.pop_front());
	endtask

	task automatic run_random(int target);
		while (sb.n_bytes < target) begin
			add_random_string();
			send_line();
		end
	endtask

	// Hold input until every result is back, then let trailing bytes settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.units_due.size() != 0)
			@(posedge clk);
		repeat (6)
			@(posedge clk);
	endtask

	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				sb.check_result({unit_value, status, string_end, last_of_run});
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_idle);
			end
		end
	end

	initial begin
		sb        = new();
		send_idle = 0;
		recv_idle = 0;
		hold_left = 0;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		data_byte <= 8'h00;
		out_stall <= 1'b0;
		repeat (12)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ascii limits, two-, three- and four-byte forms, then each error kind
		line_q = '{8'h01, 8'h7f, 8'hc2, 8'h80, 8'hef, 8'hbf, 8'hbf,
			8'hf0, 8'h90, 8'h80, 8'h80, 8'h00,
			8'hc0, 8'h80, 8'h00,
			8'hed, 8'ha0, 8'h80, 8'h00,
			8'hff, 8'h00,
			8'he2, 8'h41, 8'h00,
			8'he2, 8'h82, 8'h00};
		send_line();
		wait_idle();

		send_idle = 9;
		recv_idle = 86;
		run_random(sb.n_bytes + 140);
		wait_idle();

		send_idle = 86;
		recv_idle = 9;
		run_random(sb.n_bytes + 140);
		wait_idle();

		// long output hold-off while input keeps coming
		send_idle = 0;
		recv_idle = 0;
		hold_left = 300;
		run_random(sb.n_bytes + 50);
		run_random(sb.n_bytes + 80);
		wait_idle();

		$display("summary: %0d bytes, %0d live, %0d results, %0d surrogate pairs, %0d errors",
			sb.n_bytes, sb.n_live, sb.n_results, sb.n_pairs, sb.n_rejects);
		$display("summary: idling on each side in turn, one long output hold-off, %0d cycles",
			cycle_count);
		if (sb.mismatches == 0 && sb.units_due.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/u8to16_pkg.sv
sv/u8to16_decode.sv
sv/u8to16_outq.sv
sv/utf8_to_utf16_transcoder.sv
sv/u8to16_checker.sv
tb/tb.sv
